### hw/rtl/sfr_pkg.sv
// Shared types and constants for the sync frame receiver.
// Holds status codes, register indexes, reset values and the result record.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

   // Status codes carried with each frame result
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Configuration register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_START_ONE = 2'd0;
   localparam logic [1:0] REG_START_TWO = 2'd1;
   localparam logic [1:0] REG_END_ONE   = 2'd2;
   localparam logic [1:0] REG_END_TWO   = 2'd3;

   // Register values after reset
   localparam logic [7:0] RESET_START_ONE = 8'hAF;
   localparam logic [7:0] RESET_START_TWO = 8'hFA;
   localparam logic [7:0] RESET_END_ONE   = 8'hAF;
   localparam logic [7:0] RESET_END_TWO   = 8'hA0;

   // Number of captured frame bytes (frame bytes 2 to 9)
   localparam int unsigned CAPTURE_COUNT = 8;

   // Sync and end byte settings seen by the deframer
   typedef struct packed {
      logic [7:0] start_one;
      logic [7:0] start_two;
      logic [7:0] end_one;
      logic [7:0] end_two;
   } sfr_cfg_type;

   // One frame result
   typedef struct packed {
      logic [1:0]                          status;
      logic [4:0]                          frame_length;
      logic [CAPTURE_COUNT-1:0][7:0]       captured;
      logic [7:0]                          received_sum;
   } sfr_result_type;

endpackage

### hw/rtl/sfr_deframer.sv
// Byte-level deframer: sync hunt, body collection, checksum and overflow.
// Depends on sfr_pkg for the configuration and result records.
`timescale 1ns / 1ps

module sfr_deframer
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_LEN = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     rx_byte,
   input  sfr_cfg_type    cfg,
   output logic           res_valid,
   output sfr_result_type res
);

   localparam int unsigned CW = $clog2(MAX_FRAME_LEN + 1);
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_FRAME_LEN);

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [7:0]                     sum_ff, sum_in;
   logic [7:0]                     recent0_ff, recent0_in;
   logic [7:0]                     recent1_ff, recent1_in;
   logic [CAPTURE_COUNT-1:0][7:0]  capt_ff, capt_in;
   logic [CW-1:0]                  count_inc;
   logic                           end_seen;

   assign count_inc = count_ff + CW'(1);
   assign end_seen  = (count_ff >= CW'(3)) && (recent0_ff == cfg.end_one)
                      && (rx_byte == cfg.end_two);

   // Work out the next state and any frame result for the incoming item
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      recent0_in = recent0_ff;
      recent1_in = recent1_ff;
      capt_in    = capt_ff;
      res_valid  = 1'b0;
      res.status       = STATUS_GOOD;
      res.frame_length = 5'(count_inc);
      res.captured     = capt_ff;
      res.received_sum = recent1_ff;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == cfg.start_two) begin
               phase_in   = PH_BODY;
               count_in   = CW'(2);
               sum_in     = 8'd0;
               recent0_in = cfg.start_two;
               recent1_in = cfg.start_one;
               capt_in    = '0;
            end else if (rx_byte != cfg.start_one) begin
               phase_in = PH_HUNT;
            end
         end
         PH_BODY: begin
            // capture frame bytes 2 to 9 in place
            for (int k = 0; k < CAPTURE_COUNT; k++) begin
               if (count_ff == CW'(k + 2)) begin
                  capt_in[k] = rx_byte;
               end
            end
            res.captured = capt_in;
            if (end_seen) begin
               res_valid  = 1'b1;
               res.status = (sum_ff == recent1_ff) ? STATUS_GOOD : STATUS_MISMATCH;
               phase_in   = PH_HUNT;
               count_in   = '0;
            end else begin
               if (count_ff >= CW'(4)) begin
                  sum_in = sum_ff + recent1_ff;
               end
               recent1_in = recent0_ff;
               recent0_in = rx_byte;
               if (count_inc >= MAX_LEN) begin
                  // drop the over-long frame and resume hunting
                  res_valid        = 1'b1;
                  res.status       = STATUS_OVERFLOW;
                  res.frame_length = 5'(MAX_LEN);
                  res.received_sum = 8'd0;
                  phase_in         = PH_HUNT;
                  count_in         = '0;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         default: begin
            phase_in = (rx_byte == cfg.start_one) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
      if (!byte_valid) begin
         res_valid = 1'b0;
      end
   end

   // Hold the frame state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         count_ff   <= '0;
         sum_ff     <= 8'd0;
         recent0_ff <= 8'd0;
         recent1_ff <= 8'd0;
         capt_ff    <= '0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         recent0_ff <= recent0_in;
         recent1_ff <= recent1_in;
         capt_ff    <= capt_in;
      end
   end

endmodule

### hw/rtl/sync_frame_receiver.sv
// Sync frame receiver top level: register bank, deframer and result buffer.
// Depends on sfr_pkg and sfr_deframer.
//
// Usage:
//   Received bytes arrive on the req_ channel (req_valid/req_ready), one
//   item per byte. The block hunts for the two start bytes, collects the
//   frame until the end pair, and then offers one result item on the rsp_
//   channel with the frame length, frame bytes 2 to 9, the checksum byte
//   and a status (good, mismatch, overflow).
//   Throughput is one byte per cycle while req_ready is high. A result is
//   registered into the output register, or into the skid register while a result waits.
//   The result side has an output register and a skid register, so a byte
//   is still taken while one result waits; req_ready drops only when both
//   hold a result, and rises again as soon as rsp_ready takes one.
//   Reset (synchronous, active high) returns the sync and end bytes to their
//   defaults, empties the result buffer and puts the deframer back to
//   hunting. The APB port writes the four sync/end bytes at 0x0..0xC; it
//   should only be written while the block is idle.
`timescale 1ns / 1ps

module sync_frame_receiver
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // frame results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_frame_length,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_length_field,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_data_zero,
   output logic [7:0]  rsp_data_one,
   output logic [7:0]  rsp_data_two,
   output logic [7:0]  rsp_data_three,
   output logic [7:0]  rsp_data_four,
   output logic [7:0]  rsp_received_sum,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   sfr_cfg_type    cfg_ff;
   logic           csr_write;
   logic           byte_accept;
   logic           res_valid;
   sfr_result_type res;
   logic           out_valid_ff, skid_valid_ff;
   sfr_result_type out_ff, skid_ff;
   logic           pop;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_one <= RESET_START_ONE;
         cfg_ff.start_two <= RESET_START_TWO;
         cfg_ff.end_one   <= RESET_END_ONE;
         cfg_ff.end_two   <= RESET_END_TWO;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_START_ONE: cfg_ff.start_one <= pwdata[7:0];
            REG_START_TWO: cfg_ff.start_two <= pwdata[7:0];
            REG_END_ONE:   cfg_ff.end_one   <= pwdata[7:0];
            REG_END_TWO:   cfg_ff.end_two   <= pwdata[7:0];
            default:       cfg_ff.end_two   <= cfg_ff.end_two;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (paddr[3:2])
         REG_START_ONE: prdata = {24'd0, cfg_ff.start_one};
         REG_START_TWO: prdata = {24'd0, cfg_ff.start_two};
         REG_END_ONE:   prdata = {24'd0, cfg_ff.end_one};
         REG_END_TWO:   prdata = {24'd0, cfg_ff.end_two};
         default:       prdata = 32'd0;
      endcase
   end

   // Deframer
   assign req_ready   = !skid_valid_ff;
   assign byte_accept = req_valid && req_ready;

   sfr_deframer #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_deframer (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register with skid stage: results leave in arrival order
   assign pop = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= res_valid;
         end else begin
            out_valid_ff  <= res_valid;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= res;
         end else begin
            out_ff  <= res;
         end
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   // Drive the result ports from the output register
   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_address      = out_ff.captured[0];
   assign rsp_length_field = out_ff.captured[1];
   assign rsp_command      = out_ff.captured[2];
   assign rsp_data_zero    = out_ff.captured[3];
   assign rsp_data_one     = out_ff.captured[4];
   assign rsp_data_two     = out_ff.captured[5];
   assign rsp_data_three   = out_ff.captured[6];
   assign rsp_data_four    = out_ff.captured[7];
   assign rsp_received_sum = out_ff.received_sum;

endmodule

### hw/rtl/sfr_checker.sv
// Port-level checks for the sync frame receiver, bound to the top level.
// Depends on sfr_pkg for the status codes.
`timescale 1ns / 1ps

module sfr_checker
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_LEN = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_frame_length,
   input logic [7:0] rsp_received_sum
);

   // A waiting result holds its status and length until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_length))
      else $error("result changed while stalled");

   // Reset empties the result buffer
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // Input stalls only while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

   // Status is one of the three defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_GOOD) || (rsp_status == STATUS_MISMATCH)
         || (rsp_status == STATUS_OVERFLOW))
      else $error("undefined status code");

   // Overflow reports the maximum length and no checksum byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERFLOW) |->
         (rsp_frame_length == 5'(MAX_FRAME_LEN)) && (rsp_received_sum == 8'd0))
      else $error("overflow result malformed");

endmodule

bind sync_frame_receiver sfr_checker #(
   .MAX_FRAME_LEN(MAX_FRAME_LEN)
) u_sfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_frame_length(rsp_frame_length),
   .rsp_received_sum(rsp_received_sum)
);

### dv/testbench.sv
// Self-checking testbench for the sync frame receiver: byte driver, result monitor,
// APB register set-up and a scoreboard class holding its own deframer prediction.
// Depends on sfr_pkg and the sync_frame_receiver RTL.
`timescale 1ns / 1ps

module testbench;
   import sfr_pkg::*;

   localparam int unsigned FRAME_LIMIT = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned BYTES_PER_PHASE = 75;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {
      SEEK_START,
      SEEK_SECOND,
      IN_FRAME
   } rx_phase_type;

   // Scoreboard: tracks the deframer state and queues the frame results it predicts
   class frame_scoreboard;
      logic [7:0]     start_one, start_two, end_one, end_two;
      rx_phase_type   rx_phase;
      int unsigned    byte_pos;
      logic [7:0]     sum_so_far;
      logic [7:0]     prev_byte, prev_prev_byte;
      logic [7:0]     frame_bytes [CAPTURE_COUNT];
      sfr_result_type frames_due [$];
      int unsigned    errors;
      int unsigned    frames_seen;

      function new();
         start_one      = RESET_START_ONE;
         start_two      = RESET_START_TWO;
         end_one        = RESET_END_ONE;
         end_two        = RESET_END_TWO;
         rx_phase       = SEEK_START;
         byte_pos       = 0;
         sum_so_far     = 8'h00;
         prev_byte      = 8'h00;
         prev_prev_byte = 8'h00;
         foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
         errors         = 0;
         frames_seen    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            REG_START_ONE: start_one = value;
            REG_START_TWO: start_two = value;
            REG_END_ONE:   end_one   = value;
            REG_END_TWO:   end_two   = value;
            default: ;
         endcase
      endfunction

      function void queue_frame(logic [1:0] status, int unsigned len, logic [7:0] rsum);
         sfr_result_type r;
         r.status       = status;
         r.frame_length = len[4:0];
         for (int k = 0; k < CAPTURE_COUNT; k++) r.captured[k] = frame_bytes[k];
         r.received_sum = rsum;
         frames_due.push_back(r);
      endfunction

      // Advance the deframer by one accepted byte
      function void note_byte(logic [7:0] b);
         int unsigned p;
         case (rx_phase)
            SEEK_SECOND: begin
               if (b == start_two) begin
                  rx_phase       = IN_FRAME;
                  byte_pos       = 2;
                  sum_so_far     = 8'h00;
                  prev_byte      = start_two;
                  prev_prev_byte = start_one;
                  foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
               end else if (b != start_one) begin
                  rx_phase = SEEK_START;
               end
            end
            IN_FRAME: begin
               p = byte_pos;
               if (p >= 2 && p < 2 + CAPTURE_COUNT) frame_bytes[p - 2] = b;
               // end pair closes the frame
               if (p >= 3 && prev_byte == end_one && b == end_two) begin
                  queue_frame((sum_so_far == prev_prev_byte) ? STATUS_GOOD : STATUS_MISMATCH,
                              p + 1, prev_prev_byte);
                  rx_phase = SEEK_START;
                  byte_pos = 0;
               end else begin
                  if (p >= 4) sum_so_far = sum_so_far + prev_prev_byte;
                  prev_prev_byte = prev_byte;
                  prev_byte      = b;
                  // drop an over-long frame, the last byte is not a start candidate
                  if (p + 1 >= FRAME_LIMIT) begin
                     queue_frame(STATUS_OVERFLOW, FRAME_LIMIT, 8'h00);
                     rx_phase = SEEK_START;
                     byte_pos = 0;
                  end else begin
                     byte_pos = p + 1;
                  end
               end
            end
            default: rx_phase = (b == start_one) ? SEEK_SECOND : SEEK_START;
         endcase
      endfunction

      function void check_result(sfr_result_type got);
         sfr_result_type want;
         bit             bad;
         frames_seen++;
         if (frames_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected frame result: st=%0d len=%0d cap=%h sum=%h",
                        got.status, got.frame_length, got.captured, got.received_sum);
            return;
         end
         want = frames_due.pop_front();
         bad  = (got.status != want.status) || (got.frame_length != want.frame_length) ||
                (got.received_sum != want.received_sum);
         for (int k = 0; k < CAPTURE_COUNT; k++)
            if (got.captured[k] != want.captured[k]) bad = 1'b1;
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("frame mismatch: expected st=%0d len=%0d cap=%h sum=%h",
                        want.status, want.frame_length, want.captured, want.received_sum);
               $display("                actual   st=%0d len=%0d cap=%h sum=%h",
                        got.status, got.frame_length, got.captured, got.received_sum);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_frame_length;
   logic [7:0]  rsp_address, rsp_length_field, rsp_command;
   logic [7:0]  rsp_data_zero, rsp_data_one, rsp_data_two, rsp_data_three, rsp_data_four;
   logic [7:0]  rsp_received_sum;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'h0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   frame_scoreboard sb = new();
   sfr_result_type  rsp_item;
   int unsigned     cycle_count = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;

   sync_frame_receiver #(.MAX_FRAME_LEN(FRAME_LIMIT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_frame_length(rsp_frame_length), .rsp_address(rsp_address),
      .rsp_length_field(rsp_length_field), .rsp_command(rsp_command),
      .rsp_data_zero(rsp_data_zero), .rsp_data_one(rsp_data_one),
      .rsp_data_two(rsp_data_two), .rsp_data_three(rsp_data_three),
      .rsp_data_four(rsp_data_four), .rsp_received_sum(rsp_received_sum),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Abandon the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
   end

   // Check every accepted result item and stall the result side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_item.status       = rsp_status;
         rsp_item.frame_length = rsp_frame_length;
         rsp_item.captured[0]  = rsp_address;
         rsp_item.captured[1]  = rsp_length_field;
         rsp_item.captured[2]  = rsp_command;
         rsp_item.captured[3]  = rsp_data_zero;
         rsp_item.captured[4]  = rsp_data_one;
         rsp_item.captured[5]  = rsp_data_two;
         rsp_item.captured[6]  = rsp_data_three;
         rsp_item.captured[7]  = rsp_data_four;
         rsp_item.received_sum = rsp_received_sum;
         sb.check_result(rsp_item);
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Offer one byte item, with random idle cycles ahead of it, and hold until taken
   task send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task hold_sender;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task wait_for_frames;
      while (sb.frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task csr_write(input logic [1:0] idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] != value) begin
         sb.errors++;
         if (sb.errors <= 10)
            $display("register %0d read back %h, expected %h", idx, prdata[7:0], value);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One frame of len bytes built from the current sync and end bytes
   task send_frame(input int unsigned len, input bit sum_ok);
      logic [7:0] acc;
      logic [7:0] b;
      acc = 8'h00;
      send_byte(sb.start_one);
      send_byte(sb.start_two);
      if (len >= 6) begin
         for (int k = 0; k <= len - 6; k++) begin
            b   = 8'($urandom_range(0, 255));
            acc = acc + b;
            send_byte(b);
         end
         send_byte(sum_ok ? acc : 8'($urandom_range(0, 255)));
      end else begin
         for (int k = 0; k < len - 4; k++) send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(sb.end_one);
      send_byte(sb.end_two);
   endtask

   // Mostly well-formed frames, the rest over-long, truncated or noise
   task random_traffic(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) send_frame($urandom_range(4, 5), 1'b1);
            else send_frame($urandom_range(6, FRAME_LIMIT), $urandom_range(0, 3) != 0);
         end else if (pick < 80) begin
            send_byte(sb.start_one);
            send_byte(sb.start_two);
            repeat ($urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 2))
               send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            send_byte(sb.start_one);
            if ($urandom_range(0, 1)) send_byte(sb.start_two);
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task directed_frames;
      // junk, repeated start byte, then the shortest frame
      send_byte(8'h00);
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_TWO);
      send_byte(RESET_END_ONE);
      send_byte(RESET_END_TWO);
      // five-byte frame
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_TWO);
      send_byte(8'hFF);
      send_byte(RESET_END_ONE);
      send_byte(RESET_END_TWO);
      // good checksum
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_TWO);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      send_byte(8'h06);
      send_byte(RESET_END_ONE);
      send_byte(RESET_END_TWO);
      // overflow closed by a start byte, which must not open a new frame
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_TWO);
      repeat (FRAME_LIMIT - 3) send_byte(8'hFF);
      send_byte(RESET_START_ONE);
      send_byte(RESET_START_TWO);
   endtask

   initial begin
      logic [7:0] cfg [4];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // idle profile: none, sender, receiver, both
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 64; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         // sync and end byte settings, extremes first
         if (ph > 0) begin
            case (ph)
               1: cfg = '{8'h00, 8'h00, 8'h00, 8'h00};
               2: cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
               3: cfg = '{8'h55, 8'hAA, 8'h33, 8'hCC};
               4: cfg = '{8'h00, 8'hFF, 8'hFF, 8'h00};
               default: foreach (cfg[k]) cfg[k] = 8'($urandom_range(0, 255));
            endcase
            csr_write(REG_START_ONE, cfg[0]);
            csr_write(REG_START_TWO, cfg[1]);
            csr_write(REG_END_ONE, cfg[2]);
            csr_write(REG_END_TWO, cfg[3]);
         end
         if (ph == 0) directed_frames();
         random_traffic(BYTES_PER_PHASE);
         // flush any open frame so the deframer is hunting before the next setting
         repeat (FRAME_LIMIT) send_byte(~sb.start_one);
         hold_sender();
         wait_for_frames();
      end

      if (sb.frames_due.size() != 0) begin
         sb.errors++;
         $display("%0d frame results never arrived", sb.frames_due.size());
      end
      $display("run covered %0d byte items and %0d frame results over %0d settings",
               bytes_sent, sb.frames_seen, PHASE_COUNT);
      $display("failures: %0d", sb.errors);
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
